// File: rtl/dsse_pkg.sv
package dsse_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int MAX_DIGITS_DEFAULT = 10;

  localparam int NUM_SEGS  = 7;
  localparam int POS_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = POS_W;
  localparam int DIGIT_W   = 4;
  localparam int SEG_W     = 8;
  localparam int RADIX     = 10;
  // dividend bits consumed per divider cycle
  localparam int STEP_BITS = 8;

  localparam logic [SEG_W-1:0] SEG_TOP_BIT = 8'h80;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POS_SEG_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SEG_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SEG_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SEG_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SEG_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SEG_F = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POS_SEG_G = 3'd6;

  typedef logic [NUM_SEGS-1:0][POS_W-1:0] pos_arr_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dsse_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic div_last;
    logic last;
    logic out_busy;
  } dsse_stat_t;

  // bit k set means segment k lit, A is bit 0
  function automatic logic [NUM_SEGS-1:0] digit_segs(input logic [DIGIT_W-1:0] digit);
    logic [NUM_SEGS-1:0] lit;
    unique case (digit)
      4'd0:    lit = 7'h3F;
      4'd1:    lit = 7'h06;
      4'd2:    lit = 7'h5B;
      4'd3:    lit = 7'h4F;
      4'd4:    lit = 7'h66;
      4'd5:    lit = 7'h6D;
      4'd6:    lit = 7'h7C;
      4'd7:    lit = 7'h07;
      4'd8:    lit = 7'h7F;
      4'd9:    lit = 7'h6F;
      default: lit = '0;
    endcase
    return lit;
  endfunction

  // segments sharing a position merge by or
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit,
                                                   input pos_arr_t pos);
    logic [NUM_SEGS-1:0] lit;
    logic [SEG_W-1:0]    pat;
    lit = digit_segs(digit);
    pat = '0;
    for (int k = 0; k < NUM_SEGS; k++) begin
      if (lit[k]) begin
        pat = pat | (SEG_TOP_BIT >> pos[k]);
      end
    end
    return pat;
  endfunction

endpackage

// File: rtl/dsse_ctrl.sv
module dsse_ctrl
  import dsse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dsse_stat_t stat,
  output dsse_cmd_t  cmd,
  output logic       in_stall
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          // zero produces no digits
          if (!stat.in_zero) begin
            state_next = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = stat.last ? ST_IDLE : ST_DIVIDE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/dsse_datapath.sv
module dsse_datapath
  import dsse_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] value,
  input  dsse_cmd_t             cmd,
  output dsse_stat_t            stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [SEG_W-1:0]      segment_byte,
  output logic [DIGIT_W-1:0]    digit_value,
  output logic                  last_digit
);

  localparam int ITER     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS = ITER * STEP_BITS;
  localparam int ITER_W   = (ITER > 1) ? $clog2(ITER) : 1;
  localparam int CNT_W    = $clog2(MAX_DIGITS);

  pos_arr_t            pos;
  logic [PAD_BITS-1:0] work, work_next;
  logic [DIGIT_W-1:0]  rem, rem_next;
  logic [ITER_W-1:0]   iter;
  logic [CNT_W-1:0]    cnt;
  logic                last;

  // segment position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SEGS; k++) begin
        pos[k] <= POS_W'(k);
      end
    end else if (cfg_we && cfg_index <= REG_POS_SEG_G) begin
      pos[cfg_index] <= cfg_data;
    end
  end

  // restoring divide by ten, STEP_BITS quotient bits per cycle
  always_comb begin
    logic [DIGIT_W:0]     r;
    logic [DIGIT_W-1:0]   rc;
    logic [STEP_BITS-1:0] q;
    rc = rem;
    q  = '0;
    for (int j = 0; j < STEP_BITS; j++) begin
      r = {rc, work[PAD_BITS-1-j]};
      if (r >= (DIGIT_W+1)'(RADIX)) begin
        rc = DIGIT_W'(r - (DIGIT_W+1)'(RADIX));
        q[STEP_BITS-1-j] = 1'b1;
      end else begin
        rc = r[DIGIT_W-1:0];
      end
    end
    rem_next  = rc;
    work_next = (work << STEP_BITS) | PAD_BITS'(q);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= PAD_BITS'(value);
      rem  <= '0;
      iter <= '0;
      cnt  <= '0;
    end else if (cmd.step) begin
      work <= work_next;
      rem  <= rem_next;
      iter <= ITER_W'(iter + 1'b1);
    end else if (cmd.emit) begin
      rem  <= '0;
      iter <= '0;
      cnt  <= CNT_W'(cnt + 1'b1);
    end
  end

  // after a full division work holds the quotient
  assign last = (work == '0) || (cnt == CNT_W'(MAX_DIGITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      segment_byte <= seg_pattern(rem, pos);
      digit_value  <= rem;
      last_digit   <= last;
    end
  end

  assign stat.in_zero  = (value == '0);
  assign stat.div_last = (iter == ITER_W'(ITER - 1));
  assign stat.last     = last;
  assign stat.out_busy = out_valid && out_stall;

endmodule

// File: rtl/decimal_seven_segment_encoder_core.sv
// Decimal seven-segment encoder.
// Input channel (value, in_valid, in_stall): one transaction carries an
// unsigned number. Output channel (segment_byte, digit_value, last_digit,
// out_valid, out_stall): one transaction per decimal digit, least significant
// first, last_digit set on the most significant one (or on digit MAX_DIGITS).
// A value of zero is accepted and produces no output.
// Each digit comes from a divide-by-ten unit that takes 8 dividend bits per
// cycle; once the division of the remaining value is complete, the digit is
// loaded into the output register.
// A new value is taken once the last digit of the previous one is in the
// output register; the receiver may still hold that digit.
// When the receiver stalls, the output register holds its digit and the
// divider waits with the next one until the register frees up.
// The user must write segment positions (cfg_we/cfg_index/cfg_data) only
// while idle; the block does not enforce it. Position p lights bit 0x80 >> p.
// Reset restores positions A..G = 0..6, empties the output register and
// returns to idle.
module decimal_seven_segment_encoder_core
  import dsse_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SEG_W-1:0]      segment_byte,
  output logic [DIGIT_W-1:0]    digit_value,
  output logic                  last_digit,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  dsse_cmd_t  cmd;
  dsse_stat_t stat;

  dsse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  dsse_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .segment_byte (segment_byte),
    .digit_value  (digit_value),
    .last_digit   (last_digit)
  );

  // a pending digit is never overwritten
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("digit emitted over a stalled result");

  // a nonzero value starts work and blocks further input
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && value != '0) |=> in_stall)
    else $error("input not blocked while dividing");

  // the divider only runs while input is blocked
  assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (in_stall && !cmd.load && !cmd.emit))
    else $error("divider step outside of busy phase");

  // every emitted digit appears on the output
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted digit not presented");

endmodule

// File: tb/decimal_seven_segment_encoder_core_tb.sv
module decimal_seven_segment_encoder_core_tb
  import dsse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VAL_W      = 32;
  localparam int DIGITS_MAX = 10;
  localparam int SETTLE_CYC = 64;
  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 9;
  localparam int PHASE_ITEMS = 30;
  localparam int LONG_HOLD  = 200;

  // index past the last position register, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // lit segments per digit, digit 0 in the low 7 bits, segment A is bit 0
  localparam logic [10*NUM_SEGS-1:0] LIT_BY_DIGIT = {
    7'h6F, 7'h7F, 7'h07, 7'h7C, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef struct packed {
    logic [SEG_W-1:0]   seg;
    logic [DIGIT_W-1:0] dig;
    logic               last;
  } digit_res_t;

  typedef struct packed {
    logic [VAL_W-1:0]   val;
    logic               typed;
    logic               one_digit;
    logic [SEG_W-1:0]   seg;
    logic [DIGIT_W-1:0] dig;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [VAL_W-1:0]     value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SEG_W-1:0]     segment_byte;
  logic [DIGIT_W-1:0]   digit_value;
  logic                 last_digit;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  decimal_seven_segment_encoder_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segment_byte (segment_byte),
    .digit_value  (digit_value),
    .last_digit   (last_digit),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pos_arr_t    cur_pos;
  digit_res_t  pending_digits [$];
  int unsigned err_count = 0;
  int unsigned sink_wait = 0;
  bit          sink_gaps = 1'b1;
  bit          src_gaps = 1'b1;
  bit          long_hold_req = 1'b0;

  // after reset: A..G at positions 0..6, so at bits 7..1
  dir_row_t dir_tab [N_DIRECTED] = '{
    '{32'd0,          1'b1, 1'b0, 8'h00, 4'd0},
    '{32'd1,          1'b1, 1'b1, 8'h60, 4'd1},
    '{32'd2,          1'b1, 1'b1, 8'hDA, 4'd2},
    '{32'd3,          1'b1, 1'b1, 8'hF2, 4'd3},
    '{32'd4,          1'b1, 1'b1, 8'h66, 4'd4},
    '{32'd5,          1'b1, 1'b1, 8'hB6, 4'd5},
    '{32'd6,          1'b1, 1'b1, 8'h3E, 4'd6},
    '{32'd7,          1'b1, 1'b1, 8'hE0, 4'd7},
    '{32'd8,          1'b1, 1'b1, 8'hFE, 4'd8},
    '{32'd9,          1'b1, 1'b1, 8'hF6, 4'd9},
    '{32'd10,         1'b0, 1'b0, 8'h00, 4'd0},
    '{32'd99,         1'b0, 1'b0, 8'h00, 4'd0},
    '{32'd100,        1'b0, 1'b0, 8'h00, 4'd0},
    '{32'hFFFF_FFFF,  1'b0, 1'b0, 8'h00, 4'd0},
    '{32'hFFFF_FFFE,  1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h8000_0000,  1'b0, 1'b0, 8'h00, 4'd0},
    '{32'd1000000000, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'd1234567890, 1'b0, 1'b0, 8'h00, 4'd0},
    '{32'd987654321,  1'b0, 1'b0, 8'h00, 4'd0},
    '{32'd0,          1'b1, 1'b0, 8'h00, 4'd0},
    '{32'hAAAA_AAAA,  1'b0, 1'b0, 8'h00, 4'd0},
    '{32'h5555_5555,  1'b0, 1'b0, 8'h00, 4'd0}
  };

  function automatic logic [SEG_W-1:0] seg_byte_of(input logic [DIGIT_W-1:0] d);
    logic [NUM_SEGS-1:0] lit;
    logic [SEG_W-1:0]    pat;
    lit = LIT_BY_DIGIT[d*NUM_SEGS +: NUM_SEGS];
    pat = '0;
    for (int k = 0; k < NUM_SEGS; k++) begin
      if (lit[k]) begin
        pat = pat | (SEG_TOP_BIT >> cur_pos[k]);
      end
    end
    return pat;
  endfunction

  // least significant digit first, last mark on the top digit
  task automatic queue_digits_of(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] rest;
    digit_res_t       r;
    int               n;
    rest = v;
    n = 0;
    while (rest != 0 && n < DIGITS_MAX) begin
      r.dig = DIGIT_W'(rest % 10);
      rest = rest / 10;
      r.seg = seg_byte_of(r.dig);
      r.last = (rest == 0) || (n + 1 == DIGITS_MAX);
      pending_digits.push_back(r);
      n++;
    end
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1, 2, 3: v = $urandom;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  task automatic send_value(input logic [VAL_W-1:0] v);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      value = $urandom;
    end
    @(negedge clk);
    in_valid = 1'b1;
    value = v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  task automatic load_positions(input pos_arr_t p);
    for (int k = 0; k < NUM_SEGS; k++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = REG_POS_SEG_A + CFG_IDX_W'(k);
      cfg_data = p[k];
    end
    @(negedge clk);
    cfg_index = REG_UNUSED;
    cfg_data = CFG_W'($urandom);
    @(negedge clk);
    cfg_we = 1'b0;
    cur_pos = p;
  endtask

  // output side stall driver
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        sink_wait = LONG_HOLD;
      end
      if (sink_wait > 0) begin
        out_stall = 1'b1;
        sink_wait--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    digit_res_t got;
    digit_res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{segment_byte, digit_value, last_digit};
      if (pending_digits.size() == 0) begin
        err_count++;
        $display("%0t: unexpected digit transaction seg=%h digit=%0d last=%b",
                 $time, got.seg, got.dig, got.last);
      end else begin
        want = pending_digits.pop_front();
        if (got !== want) begin
          err_count++;
          $display("%0t: mismatch: expected seg=%h digit=%0d last=%b,",
                   $time, want.seg, want.dig, want.last,
                   " got seg=%h digit=%0d last=%b",
                   got.seg, got.dig, got.last);
        end
      end
      sink_wait = sink_gaps ? $urandom_range(0, 7) : 0;
    end
  end

  initial begin : stimulus
    pos_arr_t         p;
    logic [VAL_W-1:0] v;
    digit_res_t       r;
    for (int k = 0; k < NUM_SEGS; k++) begin
      cur_pos[k] = POS_W'(k);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      send_value(dir_tab[i].val);
      if (dir_tab[i].typed) begin
        if (dir_tab[i].one_digit) begin
          r = '{dir_tab[i].seg, dir_tab[i].dig, 1'b1};
          pending_digits.push_back(r);
        end
      end else begin
        queue_digits_of(dir_tab[i].val);
      end
    end
    idle_input();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      repeat (SETTLE_CYC) @(posedge clk);
      for (int k = 0; k < NUM_SEGS; k++) begin
        case (ph)
          0:       p[k] = '0;
          1:       p[k] = '1;
          2:       p[k] = POS_W'(NUM_SEGS - k);
          8:       p[k] = POS_W'(k);
          default: p[k] = POS_W'($urandom_range(0, 7));
        endcase
      end
      load_positions(p);
      src_gaps = (ph != 2 && ph != 3);
      sink_gaps = (ph != 2);
      // stall the output long enough for the block to back up its input
      if (ph == 3) begin
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 5 && i == PHASE_ITEMS / 2) begin
          idle_input();
          drain();
        end
        v = random_value();
        send_value(v);
        queue_digits_of(v);
      end
      idle_input();
    end

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_count == 0 && pending_digits.size() == 0) begin
      $display("decimal_seven_segment_encoder_core_tb: done, clean");
    end else begin
      $display("decimal_seven_segment_encoder_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("decimal_seven_segment_encoder_core_tb: done, errors");
    $finish;
  end

endmodule
